// ----- hdl/rbe_pkg.sv -----
package rbe_pkg;

    localparam int SIZE_BITS     = 12;
    localparam int FRAC_BITS     = 8;
    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 18;
    localparam int OUT_BITS      = 21;

    // CORDIC datapath width (Q30 values plus headroom)
    localparam int CW = 34;

    localparam int RED_W = ANGLE_BITS + 2;
    localparam logic signed [RED_W-1:0] FULL_DEG    = RED_W'(360 << FRAC_BITS);
    localparam logic signed [RED_W-1:0] QUARTER_DEG = RED_W'(90 << FRAC_BITS);

    localparam int RES_W = 15;   // residual angle below one quarter turn
    localparam int DR_W  = 25;
    localparam logic [DR_W-1:0] DEG_RAD_Q30     = DR_W'(18740330);
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = CW'(652032874);

    localparam int ZP_W      = RES_W + DR_W;
    localparam int PROD_W    = CW + SIZE_BITS + 1;
    localparam int SUM_W     = PROD_W + 1;
    localparam int RND_SHIFT = 31 - FRAC_BITS;
    localparam int RND_W     = SUM_W - RND_SHIFT;

    localparam int RED_STAGES    = 4;
    localparam int CORNER_STAGES = 4;
    localparam int LATENCY       = RED_STAGES + CORDIC_STAGES + CORNER_STAGES;

    typedef struct packed {
        logic [SIZE_BITS-1:0] w;
        logic [SIZE_BITS-1:0] h;
        logic [1:0]           q;
        logic                 rzero;
    } meta_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cord_t;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:  v = CW'(32'h3243F6A8);
            1:  v = CW'(32'h1DAC6705);
            2:  v = CW'(32'h0FADBAFC);
            3:  v = CW'(32'h07F56EA6);
            4:  v = CW'(32'h03FEAB76);
            5:  v = CW'(32'h01FFD55B);
            6:  v = CW'(32'h00FFFAAA);
            7:  v = CW'(32'h007FFF55);
            8:  v = CW'(32'h003FFFEA);
            9:  v = CW'(32'h001FFFFD);
            10: v = CW'(32'h000FFFFF);
            11: v = CW'(32'h0007FFFF);
            12: v = CW'(32'h0003FFFF);
            13: v = CW'(32'h0001FFFF);
            14: v = CW'(32'h0000FFFF);
            15: v = CW'(32'h00007FFF);
            16: v = CW'(32'h00003FFF);
            17: v = CW'(32'h00001FFF);
            18: v = CW'(32'h00000FFF);
            19: v = CW'(32'h000007FF);
            20: v = CW'(32'h000003FF);
            21: v = CW'(32'h000001FF);
            22: v = CW'(32'h000000FF);
            23: v = CW'(32'h0000007F);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/rbe_reduce.sv -----
module rbe_reduce (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            valid_in,
    input  logic [11:0]                     box_width,
    input  logic [11:0]                     box_height,
    input  logic signed [17:0]              angle,
    output logic                            valid_out,
    output rbe_pkg::meta_t                  meta_out,
    output logic signed [rbe_pkg::CW-1:0]   z_out
);

    logic [rbe_pkg::RED_STAGES-1:0] valid_reg;
    rbe_pkg::meta_t                 meta1_reg, meta2_reg, meta3_reg, meta4_reg;
    rbe_pkg::meta_t                 meta1_next, meta2_next;
    logic signed [rbe_pkg::RED_W-1:0] a_ext;
    logic signed [rbe_pkg::RED_W-1:0] a_reg, a_next;
    logic [rbe_pkg::RES_W-1:0]      r_reg, r_next;
    logic [rbe_pkg::ZP_W-1:0]       prod_reg;
    logic [rbe_pkg::ZP_W-1:0]       zsum;
    logic signed [rbe_pkg::CW-1:0]  z_reg;
    logic signed [rbe_pkg::RED_W-1:0] rem;

    // reduce into 0 .. 360 degrees; the most negative input needs two turns
    always_comb
    begin
        a_ext = rbe_pkg::RED_W'(angle);
        if (a_ext < -rbe_pkg::FULL_DEG)
            a_next = a_ext + rbe_pkg::FULL_DEG + rbe_pkg::FULL_DEG;
        else if (a_ext < 0)
            a_next = a_ext + rbe_pkg::FULL_DEG;
        else if (a_ext >= rbe_pkg::FULL_DEG)
            a_next = a_ext - rbe_pkg::FULL_DEG;
        else
            a_next = a_ext;
        meta1_next       = '0;
        meta1_next.w     = box_width[rbe_pkg::SIZE_BITS-1:0];
        meta1_next.h     = box_height[rbe_pkg::SIZE_BITS-1:0];
    end

    // quadrant and residual
    always_comb
    begin
        meta2_next = meta1_reg;
        if (a_reg >= 3 * rbe_pkg::QUARTER_DEG)
        begin
            meta2_next.q = 2'd3;
            rem = rbe_pkg::RED_W'(a_reg - 3 * rbe_pkg::QUARTER_DEG);
        end
        else if (a_reg >= 2 * rbe_pkg::QUARTER_DEG)
        begin
            meta2_next.q = 2'd2;
            rem = rbe_pkg::RED_W'(a_reg - 2 * rbe_pkg::QUARTER_DEG);
        end
        else if (a_reg >= rbe_pkg::QUARTER_DEG)
        begin
            meta2_next.q = 2'd1;
            rem = a_reg - rbe_pkg::QUARTER_DEG;
        end
        else
        begin
            meta2_next.q = 2'd0;
            rem = a_reg;
        end
        r_next           = rem[rbe_pkg::RES_W-1:0];
        meta2_next.rzero = (rem == '0);
    end

    assign zsum = prod_reg + rbe_pkg::ZP_W'(1 << (rbe_pkg::FRAC_BITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[rbe_pkg::RED_STAGES-2:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        meta1_reg <= meta1_next;
        r_reg     <= r_next;
        meta2_reg <= meta2_next;
        prod_reg  <= rbe_pkg::ZP_W'(r_reg) * rbe_pkg::ZP_W'(rbe_pkg::DEG_RAD_Q30);
        meta3_reg <= meta2_reg;
        z_reg     <= rbe_pkg::CW'(zsum[rbe_pkg::ZP_W-1:rbe_pkg::FRAC_BITS]);
        meta4_reg <= meta3_reg;
    end

    assign valid_out = valid_reg[rbe_pkg::RED_STAGES-1];
    assign meta_out  = meta4_reg;
    assign z_out     = z_reg;

endmodule

// ----- hdl/rbe_cordic_stage.sv -----
module rbe_cordic_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [4:0]                     shift,
    input  logic signed [rbe_pkg::CW-1:0]  atan,
    input  logic                           valid_in,
    input  rbe_pkg::meta_t                 meta_in,
    input  rbe_pkg::cord_t                 cord_in,
    output logic                           valid_out,
    output rbe_pkg::meta_t                 meta_out,
    output rbe_pkg::cord_t                 cord_out
);

    logic           valid_reg;
    rbe_pkg::meta_t meta_reg;
    rbe_pkg::cord_t cord_reg, cord_next;
    logic signed [rbe_pkg::CW-1:0] xs, ys;

    always_comb
    begin
        xs = cord_in.x >>> shift;
        ys = cord_in.y >>> shift;
        if (!cord_in.z[rbe_pkg::CW-1])
        begin
            cord_next.x = cord_in.x - ys;
            cord_next.y = cord_in.y + xs;
            cord_next.z = cord_in.z - atan;
        end
        else
        begin
            cord_next.x = cord_in.x + ys;
            cord_next.y = cord_in.y - xs;
            cord_next.z = cord_in.z + atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        meta_reg <= meta_in;
        cord_reg <= cord_next;
    end

    assign valid_out = valid_reg;
    assign meta_out  = meta_reg;
    assign cord_out  = cord_reg;

endmodule

// ----- hdl/rbe_corner.sv -----
module rbe_corner (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  valid_in,
    input  rbe_pkg::meta_t                        meta_in,
    input  rbe_pkg::cord_t                        cord_in,
    output logic                                  done,
    output logic [rbe_pkg::OUT_BITS-1:0]          rot_width,
    output logic [rbe_pkg::OUT_BITS-1:0]          rot_height,
    output logic signed [rbe_pkg::OUT_BITS-1:0]   corner_x [4],
    output logic signed [rbe_pkg::OUT_BITS-1:0]   corner_y [4]
);

    localparam int RW = rbe_pkg::RND_W;
    localparam int OB = rbe_pkg::OUT_BITS;

    logic [2:0]     valid_reg;
    logic           done_reg;
    rbe_pkg::meta_t meta_p_reg, meta_s_reg;

    logic signed [rbe_pkg::CW-1:0]     c, s, sn;
    logic signed [rbe_pkg::PROD_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [rbe_pkg::SUM_W-1:0]  sx_reg [4];
    logic signed [rbe_pkg::SUM_W-1:0]  sy_reg [4];
    logic signed [RW-1:0]              rx_reg [4], rx_next [4];
    logic signed [RW-1:0]              ry_reg [4], ry_next [4];
    logic [OB-1:0]                     rw_reg, rh_reg, rw_next, rh_next;
    logic signed [OB-1:0]              cx_reg [4], cy_reg [4];

    function automatic logic signed [RW-1:0] rnd(input logic signed [rbe_pkg::SUM_W-1:0] v);
        logic signed [rbe_pkg::SUM_W-1:0] t;
        t = v + rbe_pkg::SUM_W'(1 << (rbe_pkg::RND_SHIFT - 1));
        return t[rbe_pkg::SUM_W-1:rbe_pkg::RND_SHIFT];
    endfunction

    function automatic logic signed [OB-1:0] sat_s(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] hi, lo;
        hi = RW'((1 << (OB - 1)) - 1);
        lo = -RW'(1 << (OB - 1));
        if (v > hi)
            return hi[OB-1:0];
        else if (v < lo)
            return lo[OB-1:0];
        else
            return v[OB-1:0];
    endfunction

    function automatic logic [OB-1:0] sat_u(input logic [RW:0] v);
        if (v > (RW+1)'((1 << OB) - 1))
            return '1;
        else
            return v[OB-1:0];
    endfunction

    // quadrant rotation of the CORDIC result, then the sine of minus the angle
    always_comb
    begin
        case (meta_in.q)
            2'd1:    begin c = -cord_in.y; s =  cord_in.x; end
            2'd2:    begin c = -cord_in.x; s = -cord_in.y; end
            2'd3:    begin c =  cord_in.y; s = -cord_in.x; end
            default: begin c =  cord_in.x; s =  cord_in.y; end
        endcase
        sn = -s;
    end

    // right-angle corners or rounded rotated corners
    always_comb
    begin
        logic [rbe_pkg::SIZE_BITS-1:0] ew, eh;
        logic signed [RW-1:0] hx, hy;
        logic [1:0] role;
        if (meta_s_reg.q[0])
        begin
            ew = meta_s_reg.h;
            eh = meta_s_reg.w;
        end
        else
        begin
            ew = meta_s_reg.w;
            eh = meta_s_reg.h;
        end
        hx = RW'(ew) <<< (rbe_pkg::FRAC_BITS - 1);
        hy = RW'(eh) <<< (rbe_pkg::FRAC_BITS - 1);
        for (int k = 0; k < 4; k++)
        begin
            role = 2'(k) - meta_s_reg.q;
            if (meta_s_reg.rzero)
            begin
                rx_next[k] = (role == 2'd0 || role == 2'd3) ? -hx : hx;
                ry_next[k] = (role == 2'd0 || role == 2'd1) ? -hy : hy;
            end
            else
            begin
                rx_next[k] = rnd(sx_reg[k]);
                ry_next[k] = rnd(sy_reg[k]);
            end
        end
    end

    // extents: twice the largest positive coordinate
    always_comb
    begin
        logic signed [RW-1:0] xm, ym;
        xm = '0;
        ym = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (rx_reg[k] > xm)
                xm = rx_reg[k];
            if (ry_reg[k] > ym)
                ym = ry_reg[k];
        end
        rw_next = sat_u({xm, 1'b0});
        rh_next = sat_u({ym, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], valid_in};
            done_reg  <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg     <= $signed({1'b0, meta_in.w}) * c;
        pb_reg     <= $signed({1'b0, meta_in.h}) * sn;
        pc_reg     <= $signed({1'b0, meta_in.w}) * sn;
        pd_reg     <= $signed({1'b0, meta_in.h}) * c;
        meta_p_reg <= meta_in;

        sx_reg[0]  <= -rbe_pkg::SUM_W'(pa_reg) + rbe_pkg::SUM_W'(pb_reg);
        sy_reg[0]  <= -rbe_pkg::SUM_W'(pc_reg) - rbe_pkg::SUM_W'(pd_reg);
        sx_reg[1]  <=  rbe_pkg::SUM_W'(pa_reg) + rbe_pkg::SUM_W'(pb_reg);
        sy_reg[1]  <=  rbe_pkg::SUM_W'(pc_reg) - rbe_pkg::SUM_W'(pd_reg);
        sx_reg[2]  <=  rbe_pkg::SUM_W'(pa_reg) - rbe_pkg::SUM_W'(pb_reg);
        sy_reg[2]  <=  rbe_pkg::SUM_W'(pc_reg) + rbe_pkg::SUM_W'(pd_reg);
        sx_reg[3]  <= -rbe_pkg::SUM_W'(pa_reg) - rbe_pkg::SUM_W'(pb_reg);
        sy_reg[3]  <= -rbe_pkg::SUM_W'(pc_reg) + rbe_pkg::SUM_W'(pd_reg);
        meta_s_reg <= meta_p_reg;

        rx_reg     <= rx_next;
        ry_reg     <= ry_next;

        rw_reg     <= rw_next;
        rh_reg     <= rh_next;
        for (int k = 0; k < 4; k++)
        begin
            cx_reg[k] <= sat_s(rx_reg[k]);
            cy_reg[k] <= sat_s(ry_reg[k]);
        end
    end

    assign done       = done_reg;
    assign rot_width  = rw_reg;
    assign rot_height = rh_reg;
    assign corner_x   = cx_reg;
    assign corner_y   = cy_reg;

endmodule

// ----- hdl/rotated_box_extent.sv -----
// Bounding box of a rectangle rotated about its centre.
// Command channel: box_width, box_height and angle are taken at a rising edge
// where start is high and busy is low. busy is never raised, so a new
// transaction may be issued every cycle.
// Result channel: done is high for one cycle with rot_width, rot_height and
// the four corner coordinates; the receiver must take it in that cycle.
// From the accepting edge, a transaction passes through angle reduction and
// radian conversion, one pipelined stage per CORDIC iteration, and corner
// products, sums, rounding and extents. Throughput is one transaction per
// cycle, set by the fully pipelined CORDIC.
// Reset clears all valid bits; transactions in flight are dropped and no
// done is given until a new transaction works through. The pipeline has no
// stall path since the receiver cannot hold results off.
module rotated_box_extent (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [11:0]         box_width,
    input  logic [11:0]         box_height,
    input  logic signed [17:0]  angle,
    output logic                done,
    output logic [20:0]         rot_width,
    output logic [20:0]         rot_height,
    output logic signed [20:0]  corner0_x,
    output logic signed [20:0]  corner0_y,
    output logic signed [20:0]  corner1_x,
    output logic signed [20:0]  corner1_y,
    output logic signed [20:0]  corner2_x,
    output logic signed [20:0]  corner2_y,
    output logic signed [20:0]  corner3_x,
    output logic signed [20:0]  corner3_y
);

    localparam int NS = rbe_pkg::CORDIC_STAGES;

    logic           valid_c [NS+1];
    rbe_pkg::meta_t meta_c  [NS+1];
    rbe_pkg::cord_t cord_c  [NS+1];
    logic signed [rbe_pkg::CW-1:0] z0;
    logic signed [20:0] cx [4];
    logic signed [20:0] cy [4];

    assign busy = 1'b0;

    rbe_reduce u_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (start && !busy),
        .box_width  (box_width),
        .box_height (box_height),
        .angle      (angle),
        .valid_out  (valid_c[0]),
        .meta_out   (meta_c[0]),
        .z_out      (z0)
    );

    assign cord_c[0].x = rbe_pkg::CORDIC_GAIN_Q30;
    assign cord_c[0].y = '0;
    assign cord_c[0].z = z0;

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        rbe_cordic_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (5'(i)),
            .atan      (rbe_pkg::atan_q30(i)),
            .valid_in  (valid_c[i]),
            .meta_in   (meta_c[i]),
            .cord_in   (cord_c[i]),
            .valid_out (valid_c[i+1]),
            .meta_out  (meta_c[i+1]),
            .cord_out  (cord_c[i+1])
        );
    end

    rbe_corner u_corner (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (valid_c[NS]),
        .meta_in    (meta_c[NS]),
        .cord_in    (cord_c[NS]),
        .done       (done),
        .rot_width  (rot_width),
        .rot_height (rot_height),
        .corner_x   (cx),
        .corner_y   (cy)
    );

    assign corner0_x = cx[0];
    assign corner0_y = cy[0];
    assign corner1_x = cx[1];
    assign corner1_y = cy[1];
    assign corner2_x = cx[2];
    assign corner2_y = cy[2];
    assign corner3_x = cx[3];
    assign corner3_y = cy[3];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(rbe_pkg::LATENCY) done)
        else $error("result missing after accepted transaction");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, rbe_pkg::LATENCY))
        else $error("result without a transaction");

    a_even_extent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!rot_width[0] && !rot_height[0]))
        else $error("odd extent");

endmodule
